// ===== rtl/aip_pkg.sv =====
// Shared types, constants and helpers for the ASCII integer parser.
// Used by every module of the block; no dependencies of its own.
package aip_pkg;

  localparam int CHAR_W    = 8;
  localparam int VAL_W     = 64;
  localparam int HALF_W    = 32;
  localparam int CNT_W     = 10;
  localparam int BASE_W    = 5;
  localparam int DIGIT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 80;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CNT_W-1:0] MAX_CHARS = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MINUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_RESULT  = 2'd2;

  localparam logic [BASE_W-1:0] BASE_GUESS = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd31;

  typedef struct packed {
    logic               start;
    logic               minus;
    logic               zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } chr_t;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              accept_minus;
    logic              wide_result;
  } cfg_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

  function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] v;
    v = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = DIGIT_W'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = DIGIT_W'(c - CH_UA + 8'd10);
    end
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
    return (n < MAX_CHARS) ? CNT_W'(n + 1'b1) : n;
  endfunction

endpackage

// ===== rtl/ascii_integer_parser.sv =====
// Top level of the streaming ASCII integer parser.
// Instantiates aip_front, aip_queue and aip_back; depends on aip_pkg.
//
// Characters enter on the s_ stream, one per beat, with tuser high on the
// first character of each number. The configured base (8, 10, 16 or 0 to
// guess from a 0 or 0x prefix) applies from that character on; a leading
// minus may negate the value. Each number yields one beat on the m_ stream
// once the first character that is not a digit arrives; further characters
// give nothing until the next start. An unsupported base yields an all-ones
// beat with the error flag at once.
// Throughput is one character per cycle, set by the single shift-add step
// of the back stage, while the receiver does not stall. The terminating
// character is classified into the front register, queued, and then turned
// into a result beat in the result register.
// Registers are to be written on cfg_we only while no number is in progress;
// the user is bound to this, the block does not enforce it. wide_result is
// read as each result is formed. Reset restores base 10, minus allowed and
// 64-bit results, and empties the pipeline. When the receiver stalls, the
// result register holds, the four-entry queue fills and s_tready then drops.
module ascii_integer_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [aip_pkg::CHAR_W-1:0]    s_tdata,  // char_code
  input  logic                         s_tuser,  // start_of_text
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [aip_pkg::OUT_W-1:0]     m_tdata,  // parsed_value[63:0], chars_consumed[73:64],
                                                 // bad_base[74], zero fill
  input  logic                         cfg_we,
  input  logic [aip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aip_pkg::BASE_W-1:0]    cfg_data
);
  import aip_pkg::*;

  cfg_t   cfg;
  chr_t   fdata, qdata;
  qstat_t qs;
  logic   fvalid, push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base  <= BASE_DEC;
      cfg.accept_minus <= 1'b1;
      cfg.wide_result  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUMBER_BASE:  cfg.number_base  <= cfg_data;
        REG_ACCEPT_MINUS: cfg.accept_minus <= cfg_data[0];
        REG_WIDE_RESULT:  cfg.wide_result  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign push = fvalid && !qs.full;

  aip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fvalid   (fvalid),
    .fdata    (fdata),
    .q_full   (qs.full)
  );

  aip_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fdata),
    .pop   (pop),
    .rdata (qdata),
    .qs    (qs)
  );

  aip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (!qs.empty),
    .d        (qdata),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qs.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (fvalid && qs.full))
    else $error("input stalled while the queue has room");

  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[74]) |-> (m_tdata[31:0] == '1 && m_tdata[73:64] == '0))
    else $error("error beat without all-ones value and zero count");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qs.empty)
    else $error("back stage read an empty queue");

endmodule

// ===== rtl/aip_front.sv =====
// Front stage of the ASCII integer parser: accepts character beats and
// classifies each one into a compact record. Depends on aip_pkg.
module aip_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [aip_pkg::CHAR_W-1:0] s_tdata,  // char_code
  input  logic                      s_tuser,  // start_of_text
  output logic                      fvalid,
  output aip_pkg::chr_t             fdata,
  input  logic                      q_full
);
  import aip_pkg::*;

  logic advance;

  assign advance  = !fvalid || !q_full;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (advance) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      fdata.start <= s_tuser;
      fdata.minus <= (s_tdata == CH_MINUS);
      fdata.zero  <= (s_tdata == CH_ZERO);
      fdata.is_x  <= (s_tdata == CH_LX) || (s_tdata == CH_UX);
      fdata.digit <= hex_value(s_tdata);
    end
  end

endmodule

// ===== rtl/aip_queue.sv =====
// Short queue of classified characters between the front and back stages.
// Depends on aip_pkg.
module aip_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aip_pkg::chr_t     wdata,
  input  logic              pop,
  output aip_pkg::chr_t     rdata,
  output aip_pkg::qstat_t   qs
);
  import aip_pkg::*;

  chr_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rdata    = mem[rd_ptr];
  assign qs.count = count;
  assign qs.full  = (count == QCNT_W'(QDEPTH));
  assign qs.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/aip_back.sv =====
// Back stage of the ASCII integer parser: runs the parse state machine on
// classified characters and holds the result beat. Depends on aip_pkg.
module aip_back (
  input  logic                      clk,
  input  logic                      rst,
  input  aip_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  aip_pkg::chr_t             d,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [aip_pkg::OUT_W-1:0] m_tdata  // parsed_value, chars_consumed, bad_base
);
  import aip_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIRST, PH_ZERO_GUESS, PH_ZERO_HEX, PH_DIGITS, PH_X_WAIT
  } phase_t;

  phase_t             ph, ph_next;
  logic [BASE_W-1:0]  base, base_next;
  logic [VAL_W-1:0]   acc, acc_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               neg, neg_next;

  logic               emit, bad, take, fc;
  logic [BASE_W-1:0]  tbase, fc_base;
  logic [CNT_W-1:0]   tcnt;
  logic [VAL_W-1:0]   acc_src, scaled, val, mask;
  logic               neg_src, base_ok;

  assign pop     = q_valid && (!m_tvalid || m_tready);
  assign base_ok = (cfg.number_base == BASE_GUESS) || (cfg.number_base == BASE_OCT) ||
                   (cfg.number_base == BASE_DEC) || (cfg.number_base == BASE_HEX);

  always_comb begin
    unique case (tbase)
      BASE_OCT: scaled = acc_src << 3;
      BASE_DEC: scaled = (acc_src << 3) + (acc_src << 1);
      BASE_HEX: scaled = acc_src << 4;
      default:  scaled = '0;
    endcase
  end

  always_comb begin
    ph_next   = ph;
    base_next = base;
    acc_next  = acc;
    cnt_next  = cnt;
    neg_next  = neg;
    emit      = 1'b0;
    bad       = 1'b0;
    take      = 1'b0;
    fc        = 1'b0;
    tbase     = base;
    fc_base   = base;
    tcnt      = cnt;
    acc_src   = acc;
    neg_src   = neg;
    if (pop) begin
      if (d.start) begin
        acc_next  = '0;
        cnt_next  = '0;
        neg_next  = 1'b0;
        base_next = cfg.number_base;
        acc_src   = '0;
        neg_src   = 1'b0;
        tcnt      = '0;
        if (!base_ok) begin
          emit = 1'b1;
          bad  = 1'b1;
        end else if (cfg.accept_minus && d.minus) begin
          neg_next = 1'b1;
          cnt_next = sat_inc('0);
          ph_next  = PH_FIRST;
        end else begin
          fc      = 1'b1;
          fc_base = cfg.number_base;
        end
      end else begin
        unique case (ph)
          PH_FIRST: begin
            fc = 1'b1;
          end
          PH_ZERO_GUESS: begin
            if (d.is_x) begin
              ph_next = PH_X_WAIT;
            end else begin
              base_next = BASE_OCT;
              tbase     = BASE_OCT;
              take      = 1'b1;
            end
          end
          PH_X_WAIT: begin
            if (d.digit < BASE_HEX) begin
              base_next = BASE_HEX;
              tbase     = BASE_HEX;
              tcnt      = sat_inc(cnt);
              take      = 1'b1;
            end else begin
              base_next = BASE_OCT;
              emit      = 1'b1;
            end
          end
          PH_ZERO_HEX: begin
            if (d.is_x) begin
              cnt_next = sat_inc(cnt);
              ph_next  = PH_DIGITS;
            end else begin
              take = 1'b1;
            end
          end
          PH_DIGITS: begin
            take = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (fc) begin
        if (fc_base == BASE_GUESS) begin
          if (d.zero) begin
            cnt_next = sat_inc(tcnt);
            ph_next  = PH_ZERO_GUESS;
          end else begin
            base_next = BASE_DEC;
            tbase     = BASE_DEC;
            take      = 1'b1;
          end
        end else if (fc_base == BASE_OCT && d.zero) begin
          cnt_next = sat_inc(tcnt);
          ph_next  = PH_DIGITS;
        end else if (fc_base == BASE_HEX && d.zero) begin
          cnt_next = sat_inc(tcnt);
          ph_next  = PH_ZERO_HEX;
        end else begin
          tbase = fc_base;
          take  = 1'b1;
        end
      end

      if (take) begin
        if (d.digit < tbase) begin
          acc_next = scaled + VAL_W'(d.digit);
          cnt_next = sat_inc(tcnt);
          ph_next  = PH_DIGITS;
        end else begin
          emit = 1'b1;
        end
      end

      if (emit) begin
        ph_next = PH_IDLE;
      end
    end
  end

  assign mask = cfg.wide_result ? {VAL_W{1'b1}} : VAL_W'({HALF_W{1'b1}});

  always_comb begin
    if (bad) begin
      val = mask;
    end else if (neg_src) begin
      val = (-acc_src) & mask;
    end else begin
      val = acc_src & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= PH_IDLE;
      base     <= '0;
      acc      <= '0;
      cnt      <= '0;
      neg      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      ph   <= ph_next;
      base <= base_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      neg  <= neg_next;
      if (pop && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_tdata <= {5'b0, bad, (bad ? {CNT_W{1'b0}} : tcnt), val};
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ascii_integer_parser: a directed table of strings, then
// random number strings and noise, checked against the table or an in-bench model.
// Depends on aip_pkg and the block's RTL; needs no files or arguments.
module testbench;
  import aip_pkg::*;

  localparam int SETTLE      = 12;
  localparam int IDLE_LIMIT  = 4000;
  localparam int ITEM_TARGET = 180;
  localparam int LONG_DIGITS = 1030;

  typedef enum logic [2:0] {
    P_IDLE, P_SIGNED, P_LEAD_ZERO, P_ZERO_X, P_HEX_ZERO, P_DIGITS
  } parse_state_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

  typedef enum logic [1:0] {ROW_SETUP, ROW_CHAR, ROW_CHECK} row_kind_t;

  typedef struct packed {
    logic              bad;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  value;
  } result_t;

  typedef struct {
    row_kind_t         kind;
    logic              start;
    logic [CHAR_W-1:0] ch;
    result_t           want;
    logic [BASE_W-1:0] base;
    logic              minus;
    logic              wide;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CHAR_W-1:0]    s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUMBER_BASE;
  logic [BASE_W-1:0]    cfg_data = '0;

  ascii_integer_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Parser model: register copies and per-number state.
  logic [BASE_W-1:0] cfg_base  = BASE_DEC;
  logic              cfg_minus = 1'b1;
  logic              cfg_wide  = 1'b1;
  parse_state_t      parse_state = P_IDLE;
  logic [BASE_W-1:0] run_base = '0;
  logic [VAL_W-1:0]  acc = '0;
  logic [CNT_W-1:0]  cnt = '0;
  logic              neg = 1'b0;

  result_t pending_results[$];
  row_t    stim_rows[$];
  int      items_sent = 0;
  int      items_ignored = 0;
  int      results_seen = 0;
  int      setups = 0;
  int      errors = 0;
  int      burst_left = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return DIGIT_W'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return DIGIT_W'(c - CH_UA + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic void count_char();
    if (cnt < MAX_CHARS) cnt++;
  endfunction

  function automatic result_t close_number();
    logic [VAL_W-1:0] v;
    v = neg ? -acc : acc;
    parse_state = P_IDLE;
    return {1'b0, cnt, cfg_wide ? v : {{HALF_W{1'b0}}, v[HALF_W-1:0]}};
  endfunction

  function automatic bit take_digit(input logic [CHAR_W-1:0] c, output result_t r);
    logic [DIGIT_W-1:0] d;
    d = digit_of(c);
    r = '0;
    if (d < run_base) begin
      acc = acc * 64'(run_base) + 64'(d);
      count_char();
      parse_state = P_DIGITS;
      return 1'b0;
    end
    r = close_number();
    return 1'b1;
  endfunction

  function automatic bit first_digit(input logic [CHAR_W-1:0] c, output result_t r);
    r = '0;
    if (run_base == BASE_GUESS) begin
      if (c == CH_ZERO) begin
        count_char();
        parse_state = P_LEAD_ZERO;
        return 1'b0;
      end
      run_base = BASE_DEC;
    end else if (run_base == BASE_OCT && c == CH_ZERO) begin
      count_char();
      parse_state = P_DIGITS;
      return 1'b0;
    end else if (run_base == BASE_HEX && c == CH_ZERO) begin
      count_char();
      parse_state = P_HEX_ZERO;
      return 1'b0;
    end
    return take_digit(c, r);
  endfunction

  function automatic bit predict_parse(input logic st, input logic [CHAR_W-1:0] c,
                                       output result_t r);
    r = '0;
    if (st) begin
      acc = '0;
      cnt = '0;
      neg = 1'b0;
      run_base = cfg_base;
      if (cfg_base != BASE_GUESS && cfg_base != BASE_OCT &&
          cfg_base != BASE_DEC && cfg_base != BASE_HEX) begin
        parse_state = P_IDLE;
        r = {1'b1, {CNT_W{1'b0}}, cfg_wide ? {VAL_W{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}}};
        return 1'b1;
      end
      if (cfg_minus && c == CH_MINUS) begin
        neg = 1'b1;
        count_char();
        parse_state = P_SIGNED;
        return 1'b0;
      end
      return first_digit(c, r);
    end
    case (parse_state)
      P_SIGNED: return first_digit(c, r);
      P_LEAD_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          parse_state = P_ZERO_X;
          return 1'b0;
        end
        run_base = BASE_OCT;
        return take_digit(c, r);
      end
      P_ZERO_X: begin
        if (digit_of(c) != DIGIT_NONE) begin
          run_base = BASE_HEX;
          count_char();
          return take_digit(c, r);
        end
        run_base = BASE_OCT;
        r = close_number();
        return 1'b1;
      end
      P_HEX_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          count_char();
          parse_state = P_DIGITS;
          return 1'b0;
        end
        return take_digit(c, r);
      end
      P_DIGITS: return take_digit(c, r);
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_setup(input logic [BASE_W-1:0] b, input logic m, input logic w);
    row_t row;
    row = '{ROW_SETUP, 1'b0, '0, '0, b, m, w};
    stim_rows.push_back(row);
  endtask

  task automatic add_char(input logic st, input logic [CHAR_W-1:0] ch);
    row_t row;
    row = '{ROW_CHAR, st, ch, '0, '0, 1'b0, 1'b0};
    stim_rows.push_back(row);
  endtask

  task automatic add_check(input logic st, input logic [CHAR_W-1:0] ch,
                           input logic [VAL_W-1:0] value, input logic [CNT_W-1:0] count,
                           input logic bad);
    row_t row;
    row = '{ROW_CHECK, st, ch, {bad, count, value}, '0, 1'b0, 1'b0};
    stim_rows.push_back(row);
  endtask

  // Sends one character in bursts separated by random gaps; a typed expectation
  // replaces the model's where the table gives one.
  task automatic feed(input logic st, input logic [CHAR_W-1:0] ch,
                      input bit use_want = 1'b0, input result_t want = '0);
    result_t r;
    bit      got;
    if (st || parse_state != P_IDLE) items_sent++;
    else items_ignored++;
    got = predict_parse(st, ch, r);
    if (use_want) pending_results.push_back(want);
    else if (got) pending_results.push_back(r);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= st;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Writes all three registers once the block has drained.
  task automatic apply_setup(input logic [BASE_W-1:0] b, input logic m, input logic w);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUMBER_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_ACCEPT_MINUS;
    cfg_data  <= BASE_W'(m);
    @(posedge clk);
    cfg_index <= REG_WIDE_RESULT;
    cfg_data  <= BASE_W'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_base  = b;
    cfg_minus = m;
    cfg_wide  = w;
    setups++;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: m_tready <= 1'b1;
      RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
      default:    m_tready <= ~m_tready;
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[$bits(result_t)-1:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, value %h count %0d bad %b",
                 $time, seen.value, seen.count, seen.bad);
      end else begin
        want = pending_results.pop_front();
        if (seen.value !== want.value) begin
          errors++;
          $display("%0t: parsed_value expected %h actual %h", $time, want.value, seen.value);
        end
        if (seen.count !== want.count) begin
          errors++;
          $display("%0t: chars_consumed expected %0d actual %0d", $time, want.count, seen.count);
        end
        if (seen.bad !== want.bad) begin
          errors++;
          $display("%0t: bad_base expected %b actual %b", $time, want.bad, seen.bad);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still outstanding",
               $time, IDLE_LIMIT, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : main
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] term;
    logic [BASE_W-1:0] b;
    int                eff_base;
    int                ndig;
    int                v;
    int                target;
    int                phase_end;
    int                pick;

    add_setup(BASE_DEC, 1'b1, 1'b1);
    add_char(1'b1, CH_MINUS);
    add_char(1'b0, "1");
    add_check(1'b0, 8'h00, '1, 10'd2, 1'b0);
    add_char(1'b0, CH_LA);
    add_setup(BASE_HEX, 1'b1, 1'b0);
    add_char(1'b1, "F");
    add_char(1'b0, "f");
    add_check(1'b0, "g", 64'hFF, 10'd2, 1'b0);
    add_char(1'b1, CH_ZERO);
    add_char(1'b0, CH_UX);
    add_check(1'b0, "G", 64'd0, 10'd2, 1'b0);
    add_setup(BASE_GUESS, 1'b1, 1'b1);
    add_char(1'b1, CH_ZERO);
    add_char(1'b0, CH_LX);
    add_check(1'b0, "z", 64'd0, 10'd1, 1'b0);
    add_char(1'b1, CH_ZERO);
    add_char(1'b0, CH_UX);
    add_char(1'b0, "F");
    add_check(1'b0, 8'hFF, 64'd15, 10'd3, 1'b0);
    add_char(1'b1, "7");
    add_char(1'b1, CH_ZERO);
    add_char(1'b0, "7");
    add_check(1'b0, "9", 64'd7, 10'd2, 1'b0);
    add_setup(5'd31, 1'b1, 1'b0);
    add_check(1'b1, CH_MINUS, 64'hFFFF_FFFF, 10'd0, 1'b1);
    add_setup(BASE_OCT, 1'b0, 1'b1);
    add_check(1'b1, CH_MINUS, 64'd0, 10'd0, 1'b0);
    add_char(1'b1, CH_ZERO);
    add_char(1'b0, "7");
    add_check(1'b0, "8", 64'd7, 10'd2, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_SETUP: apply_setup(stim_rows[i].base, stim_rows[i].minus, stim_rows[i].wide);
        ROW_CHAR:  feed(stim_rows[i].start, stim_rows[i].ch);
        default:   feed(stim_rows[i].start, stim_rows[i].ch, 1'b1, stim_rows[i].want);
      endcase
    end

    // One number long enough to saturate the character count.
    apply_setup(BASE_DEC, 1'b1, 1'b1);
    feed(1'b1, "9");
    repeat (LONG_DIGITS - 1) feed(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
    feed(1'b0, 8'h20);

    target = items_sent + ITEM_TARGET;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        do b = BASE_W'($urandom_range(0, 31));
        while (b == BASE_GUESS || b == BASE_OCT || b == BASE_DEC || b == BASE_HEX);
      end else if (pick <= 3) b = BASE_GUESS;
      else if (pick <= 5) b = BASE_HEX;
      else if (pick <= 7) b = BASE_OCT;
      else b = BASE_DEC;
      apply_setup(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      phase_end = items_sent + $urandom_range(15, 40);
      while (items_sent < phase_end && items_sent < target) begin
        if ($urandom_range(0, 3) != 0) begin
          text = {};
          eff_base = 10;
          if ($urandom_range(0, 3) == 0) text.push_back(CH_MINUS);
          pick = $urandom_range(0, 3);
          if (cfg_base == BASE_GUESS) begin
            if (pick != 0) text.push_back(CH_ZERO);
            if (pick == 2) text.push_back(CH_LX);
            if (pick == 3) text.push_back(CH_UX);
            eff_base = (pick == 0) ? 10 : (pick == 1) ? 8 : 16;
          end else if (cfg_base == BASE_HEX) begin
            if (pick != 0) text.push_back(CH_ZERO);
            if (pick == 2) text.push_back(CH_LX);
            if (pick == 3) text.push_back(CH_UX);
            eff_base = 16;
          end else if (cfg_base == BASE_OCT) begin
            if (pick >= 2) text.push_back(CH_ZERO);
            eff_base = 8;
          end
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
          repeat (ndig) begin
            v = $urandom_range(0, eff_base - 1);
            if (v < 10) text.push_back(CH_ZERO + 8'(v));
            else text.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10));
          end
          do term = 8'($urandom_range(0, 255));
          while (digit_of(term) != DIGIT_NONE);
          foreach (text[k]) feed(k == 0, text[k]);
          feed(text.size() == 0, term);
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) feed(1'b0, 8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 6))
            feed($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        end
      end
      if (parse_state != P_IDLE) feed(1'b0, 8'h20);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Parsed %0d characters over %0d register settings (%0d ignored while idle);",
             items_sent, setups, items_ignored);
    $display("%0d results checked over guessed, octal, decimal, hex and invalid bases.",
             results_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aip_pkg.sv
rtl/aip_front.sv
rtl/aip_queue.sv
rtl/aip_back.sv
rtl/ascii_integer_parser.sv
bench/testbench.sv
